/* rtl/smre_pkg.sv */
// Shared constants, types, the exponent table and the exponent function of the softmax row engine.
package smre_pkg;

   localparam int ROW_MAX         = 64;
   localparam int ADDR_WIDTH      = $clog2(ROW_MAX);
   localparam int COUNT_WIDTH     = ADDR_WIDTH + 1;
   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS       = 12;
   localparam int FUNC_WIDTH      = 2;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_WIDTH   = $clog2(EXP_TABLE_DEPTH);
   localparam int DIV_STEPS       = 14;
   localparam int LOG_STEPS       = 30;

   localparam logic [17:0] LOG2E_Q16 = 18'd94548;
   localparam longint unsigned LN2_Q32 = 64'd2977044472;
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   typedef enum logic [1:0] {
      FUNC_SOFTMAX     = 2'd0,
      FUNC_SOFTMAX_BWD = 2'd1,
      FUNC_LOG_SOFTMAX = 2'd2,
      FUNC_LOG_BWD     = 2'd3
   } func_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]      count;
      func_type                    mode;
      logic signed [DATA_WIDTH-1:0] row_max;
   } desc_type;

   typedef struct packed {
      logic                         en;
      logic [ADDR_WIDTH-1:0]        addr;
      logic signed [DATA_WIDTH-1:0] value;
      logic signed [DATA_WIDTH-1:0] grad;
   } store_wr_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_MUL,
      ST_ACC_EXP,
      ST_ACC_SUM,
      ST_LOG_INIT,
      ST_LOG_SQ,
      ST_LOG_LN,
      ST_PREP,
      ST_OUT_RD,
      ST_OUT_MUL,
      ST_OUT_RND,
      ST_OUT_EXP,
      ST_OUT_DIV,
      ST_OUT_PLO,
      ST_OUT_PHI,
      ST_EMIT,
      ST_DONE
   } back_state_type;

   typedef logic [31:0] exp_tab_type [EXP_TABLE_DEPTH];

   function automatic exp_tab_type build_exp_table();
      exp_tab_type     tab;
      longint unsigned y;
      longint unsigned term;
      longint unsigned sum;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         y = (64'(i) * LN2_Q32) / EXP_TABLE_DEPTH;
         term = 64'd1 << 32;
         sum = term;
         for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 32) / 64'(n);
            sum = sum + term;
         end
         tab[i] = 32'((sum + 64'd2) >> 2);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TABLE = build_exp_table();

   // Argument is the base-2 exponent in Q12; the result is in Q30.
   function automatic logic [62:0] exp_q30(input logic signed [18:0] u);
      logic signed [6:0]        k;
      logic [EXP_IDX_WIDTH-1:0] idx;
      logic [31:0]              t;
      logic [5:0]               sh;
      logic [62:0]              r;
      k = u[18:12];
      idx = u[11:12-EXP_IDX_WIDTH];
      t = EXP_TABLE[idx];
      sh = 6'(-k);
      if (k < 0) begin
         if (k <= -7'sd63) begin
            r = '0;
         end else begin
            r = {31'b0, t} >> sh;
         end
      end else if (k > 7'sd31) begin
         r = 63'(1) << 62;
      end else begin
         r = {31'b0, t} << k[4:0];
      end
      return r;
   endfunction

endpackage

/* rtl/smre_req_if.sv */
// Request channel interface: one row element per transaction.
interface smre_req_if import smre_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [FUNC_WIDTH-1:0]        func;
   logic signed [DATA_WIDTH-1:0] value_in;
   logic signed [DATA_WIDTH-1:0] grad_in;
   logic                         row_end;

   modport source(output valid, func, value_in, grad_in, row_end, input ready);
   modport sink(input valid, func, value_in, grad_in, row_end, output ready);
endinterface

/* rtl/smre_rsp_if.sv */
// Response channel interface: one result element per transaction.
interface smre_rsp_if import smre_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value_out;
   logic                         row_end_out;
   logic                         saturated;

   modport source(output valid, value_out, row_end_out, saturated, input ready);
   modport sink(input valid, value_out, row_end_out, saturated, output ready);
endinterface

/* rtl/smre_front.sv */
// Front end: accepts row elements, tracks count, mode and maximum, and hands off finished rows.
module smre_front import smre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   smre_req_if.sink     req_chan,
   input  logic         queue_full,
   input  logic         row_done,
   output logic         push,
   output desc_type     push_desc,
   output store_wr_type store_wr
);

   logic [COUNT_WIDTH-1:0]       fill_ff, fill_in;
   func_type                     mode_ff, mode_in;
   logic signed [DATA_WIDTH-1:0] max_ff, max_in;
   logic                         busy_ff, busy_in;
   logic                         accept;
   logic                         last;
   func_type                     cur_mode;
   logic signed [DATA_WIDTH-1:0] cur_max;

   assign req_chan.ready = !busy_ff && !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign last = req_chan.row_end || (fill_ff == COUNT_WIDTH'(ROW_MAX - 1));

   always_comb begin
      cur_mode = (fill_ff == '0) ? func_type'(req_chan.func) : mode_ff;
      cur_max = (req_chan.value_in > max_ff) ? req_chan.value_in : max_ff;
      fill_in = fill_ff;
      mode_in = mode_ff;
      max_in = max_ff;
      busy_in = busy_ff;
      if (row_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         mode_in = cur_mode;
         if (last) begin
            fill_in = '0;
            max_in = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            busy_in = 1'b1;
         end else begin
            fill_in = fill_ff + 1'b1;
            max_in = cur_max;
         end
      end
   end

   assign push = accept && last;
   assign push_desc = '{count: fill_ff + 1'b1, mode: cur_mode, row_max: cur_max};
   assign store_wr = '{en: accept, addr: fill_ff[ADDR_WIDTH-1:0],
                       value: req_chan.value_in, grad: req_chan.grad_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         mode_ff <= FUNC_SOFTMAX;
         max_ff <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
         busy_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         mode_ff <= mode_in;
         max_ff <= max_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* rtl/smre_queue.sv */
// Two-entry queue of row descriptors between the front end and the back end.
module smre_queue import smre_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output desc_type pop_desc
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_desc = entry_ff[rd_ptr_ff];
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/smre_back.sv */
// Back end: row stores, the accumulate, log, divide and output sequencer, and the output register.
module smre_back import smre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  store_wr_type store_wr,
   input  logic         q_valid,
   input  desc_type     q_desc,
   output logic         q_pop,
   output logic         row_done,
   smre_rsp_if.source   rsp_chan
);

   logic signed [DATA_WIDTH-1:0] value_mem [ROW_MAX];
   logic signed [DATA_WIDTH-1:0] grad_mem [ROW_MAX];
   logic signed [DATA_WIDTH-1:0] rd_value_ff;
   logic signed [DATA_WIDTH-1:0] rd_grad_ff;

   back_state_type state_ff, state_in;
   desc_type       desc_ff, desc_in;
   logic [ADDR_WIDTH-1:0] idx_ff, idx_in;
   logic [4:0]     step_ff, step_in;

   logic signed [39:0] acc_ff, acc_in;
   logic signed [44:0] mul_ff, mul_in;
   logic [43:0]        e_ff, e_in;
   logic signed [27:0] dfb_ff, dfb_in;
   logic signed [17:0] lse_ff, lse_in;
   logic [30:0]        logx_ff, logx_in;
   logic [29:0]        frac_ff, frac_in;
   logic [2:0]         logm_ff, logm_in;
   logic [44:0]        rem_ff, rem_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic signed [44:0] plo_ff, plo_in;
   logic signed [47:0] res_ff, res_in;

   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_sat_ff, out_sat_in;

   logic        last_elem;
   logic        fwd_mode;
   logic        slot_free;
   logic signed [16:0] xdiff;
   logic signed [16:0] xsel;
   logic signed [34:0] exp_prod;
   logic signed [28:0] diff;
   logic [36:0] sum_s;
   logic [2:0]  m_sel;
   logic [61:0] sq;
   logic [31:0] sq_sh;
   logic [62:0] ln_prod;
   logic [32:0] l2;
   logic [50:0] trial;
   logic        take;
   logic signed [44:0] phi;
   logic signed [67:0] total;
   logic signed [37:0] tval;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         value_mem[store_wr.addr] <= store_wr.value;
         grad_mem[store_wr.addr] <= store_wr.grad;
      end
      rd_value_ff <= value_mem[idx_ff];
      rd_grad_ff <= grad_mem[idx_ff];
   end

   assign last_elem = ({1'b0, idx_ff} == desc_ff.count - 1'b1);
   assign fwd_mode = (desc_ff.mode == FUNC_SOFTMAX) || (desc_ff.mode == FUNC_LOG_SOFTMAX);
   assign slot_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      xdiff = 17'(rd_value_ff) - 17'(desc_ff.row_max);
      xsel = (desc_ff.mode == FUNC_LOG_BWD) ? 17'(rd_value_ff) : xdiff;
      exp_prod = 35'(xsel) * $signed({17'b0, LOG2E_Q16});
      diff = 29'(rd_grad_ff) - 29'(dfb_ff);
      sum_s = acc_ff[36:0];
      m_sel = '0;
      for (int j = 1; j <= 6; j++) begin
         if (sum_s[30 + j]) begin
            m_sel = 3'(j);
         end
      end
      sq = 62'(logx_ff) * 62'(logx_ff);
      sq_sh = sq[61:30];
      l2 = {logm_ff, frac_ff};
      ln_prod = 63'(l2) * 63'(LN2_Q30);
      trial = 51'(sum_s) << (4'(DIV_STEPS - 1) - step_ff[3:0]);
      take = (51'(rem_ff) >= trial);
      phi = $signed({1'b0, e_ff[43:22]}) * $signed(acc_ff[21:0]);
      total = (68'(phi) <<< 22) + 68'(plo_ff) + 68'(1 << 29);
      tval = total[67:30];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (q_valid) state_in = ST_ACC_RD;
         ST_ACC_RD:   state_in = ST_ACC_MUL;
         ST_ACC_MUL:  state_in = fwd_mode ? ST_ACC_EXP : ST_ACC_SUM;
         ST_ACC_EXP:  state_in = ST_ACC_SUM;
         ST_ACC_SUM: begin
            if (!last_elem) begin
               state_in = ST_ACC_RD;
            end else if (desc_ff.mode == FUNC_LOG_SOFTMAX) begin
               state_in = ST_LOG_INIT;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_LOG_INIT: state_in = ST_LOG_SQ;
         ST_LOG_SQ:   if (step_ff == 5'(LOG_STEPS - 1)) state_in = ST_LOG_LN;
         ST_LOG_LN:   state_in = ST_PREP;
         ST_PREP:     state_in = ST_OUT_RD;
         ST_OUT_RD:   state_in = ST_OUT_MUL;
         ST_OUT_MUL: begin
            case (desc_ff.mode)
               FUNC_SOFTMAX_BWD: state_in = ST_OUT_RND;
               FUNC_LOG_SOFTMAX: state_in = ST_EMIT;
               default:          state_in = ST_OUT_EXP;
            endcase
         end
         ST_OUT_RND:  state_in = ST_EMIT;
         ST_OUT_EXP:  state_in = (desc_ff.mode == FUNC_SOFTMAX) ? ST_OUT_DIV : ST_OUT_PLO;
         ST_OUT_DIV:  if (step_ff == 5'(DIV_STEPS - 1)) state_in = ST_EMIT;
         ST_OUT_PLO:  state_in = ST_OUT_PHI;
         ST_OUT_PHI:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = last_elem ? ST_DONE : ST_OUT_RD;
            end
         end
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      desc_in = desc_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      mul_in = mul_ff;
      e_in = e_ff;
      dfb_in = dfb_ff;
      lse_in = lse_ff;
      logx_in = logx_ff;
      frac_in = frac_ff;
      logm_in = logm_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      plo_in = plo_ff;
      res_in = res_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_last_in = out_last_ff;
      out_sat_in = out_sat_ff;
      q_pop = 1'b0;
      row_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               desc_in = q_desc;
               idx_in = '0;
               acc_in = '0;
            end
         end
         ST_ACC_MUL: begin
            case (desc_ff.mode)
               FUNC_SOFTMAX_BWD: mul_in = 45'(rd_grad_ff) * 45'(rd_value_ff);
               FUNC_LOG_BWD:     mul_in = 45'(rd_grad_ff);
               default:          mul_in = 45'(exp_prod);
            endcase
         end
         ST_ACC_EXP: e_in = 44'(exp_q30(mul_ff[34:16]));
         ST_ACC_SUM: begin
            acc_in = acc_ff + (fwd_mode ? $signed({1'b0, e_ff[38:0]}) : 40'(mul_ff));
            idx_in = last_elem ? '0 : idx_ff + 1'b1;
         end
         ST_LOG_INIT: begin
            logm_in = m_sel;
            logx_in = 31'(sum_s >> m_sel);
            frac_in = '0;
            step_in = '0;
         end
         ST_LOG_SQ: begin
            frac_in = {frac_ff[28:0], sq_sh[31]};
            logx_in = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
            step_in = step_ff + 1'b1;
         end
         ST_LOG_LN: begin
            lse_in = 18'((ln_prod[62:30] + 33'(1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
         end
         ST_PREP: dfb_in = 28'((acc_ff + 40'sd2048) >>> FRAC_BITS);
         ST_OUT_MUL: begin
            case (desc_ff.mode)
               FUNC_SOFTMAX_BWD: mul_in = 45'(rd_value_ff) * 45'(diff);
               FUNC_LOG_SOFTMAX: res_in = 48'(xdiff) - 48'(lse_ff);
               default:          mul_in = 45'(exp_prod);
            endcase
         end
         ST_OUT_RND: res_in = 48'((mul_ff + 45'sd2048) >>> FRAC_BITS);
         ST_OUT_EXP: begin
            e_in = 44'(exp_q30(mul_ff[34:16]));
            rem_in = (45'(exp_q30(mul_ff[34:16])) << FRAC_BITS) + 45'(sum_s >> 1);
            quo_in = '0;
            step_in = '0;
         end
         ST_OUT_DIV: begin
            if (take) begin
               rem_in = rem_ff - trial[44:0];
            end
            quo_in = {quo_ff[DIV_STEPS-2:0], take};
            res_in = 48'({quo_ff[DIV_STEPS-2:0], take});
            step_in = step_ff + 1'b1;
         end
         ST_OUT_PLO: plo_in = $signed({1'b0, e_ff[21:0]}) * $signed(acc_ff[21:0]);
         ST_OUT_PHI: res_in = 48'(rd_grad_ff) - 48'(tval);
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in = last_elem;
               if (res_ff > 48'sd32767) begin
                  out_value_in = 16'sh7fff;
                  out_sat_in = 1'b1;
               end else if (res_ff < -48'sd32768) begin
                  out_value_in = 16'sh8000;
                  out_sat_in = 1'b1;
               end else begin
                  out_value_in = res_ff[DATA_WIDTH-1:0];
                  out_sat_in = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: row_done = 1'b1;
         default: ;
      endcase
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.value_out = out_value_ff;
   assign rsp_chan.row_end_out = out_last_ff;
   assign rsp_chan.saturated = out_sat_ff;

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      acc_ff <= acc_in;
      mul_ff <= mul_in;
      e_ff <= e_in;
      dfb_ff <= dfb_in;
      lse_ff <= lse_in;
      logx_ff <= logx_in;
      frac_ff <= frac_in;
      logm_ff <= logm_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      plo_ff <= plo_in;
      res_ff <= res_in;
      out_value_ff <= out_value_in;
      out_last_ff <= out_last_in;
      out_sat_ff <= out_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         step_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/softmax_row_engine.sv */
// Softmax row engine top level: front end, row descriptor queue and back end.
// A row of up to 64 Q4.12 elements loads at one element per cycle while the
// front end is not busy and the queue is not full; the row closes on the element
// marked row_end or on the 64th element. The back end then makes one accumulate
// pass (read, multiply, exponent and sum per element for forward modes; the
// exponent step is skipped for backward modes) and one output pass, whose softmax
// path runs a restoring divider. Log-softmax runs an iterative log unit between
// the passes. The next row is accepted once the back end has released the row
// stores.
module softmax_row_engine import smre_pkg::*; (
   input logic        clock,
   input logic        reset,
   smre_req_if.sink   req_chan,
   smre_rsp_if.source rsp_chan
);

   logic         queue_full;
   logic         row_done;
   logic         push;
   desc_type     push_desc;
   store_wr_type store_wr;
   logic         q_pop;
   logic         q_valid;
   desc_type     q_desc;

   smre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .row_done   (row_done),
      .push       (push),
      .push_desc  (push_desc),
      .store_wr   (store_wr)
   );

   smre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (q_desc)
   );

   smre_back u_back (
      .clock    (clock),
      .reset    (reset),
      .store_wr (store_wr),
      .q_valid  (q_valid),
      .q_desc   (q_desc),
      .q_pop    (q_pop),
      .row_done (row_done),
      .rsp_chan (rsp_chan)
   );

endmodule
